// ===== rtl/cfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared widths, codes and pipeline payload types of the cube face select
// and projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package cfs_pkg;

	localparam int COMP_BITS      = 16;
	localparam int FRAC_BITS      = 14;
	localparam int COORD_BITS     = FRAC_BITS + 4;
	localparam int NUM_BITS       = COMP_BITS + FRAC_BITS;
	localparam int FACE_BITS      = 3;
	localparam int STATUS_BITS    = 2;
	localparam int BITS_PER_STAGE = 3;
	localparam int DIV_STAGES     = (COORD_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
	localparam int CNT_BITS       = $clog2(COORD_BITS + 1);

	typedef logic [FACE_BITS-1:0]          face_t;
	typedef logic [STATUS_BITS-1:0]        status_t;
	typedef logic signed [COMP_BITS-1:0]   comp_t;
	typedef logic [COMP_BITS-1:0]          mag_t;
	typedef logic [NUM_BITS-1:0]           num_t;
	typedef logic [COORD_BITS-1:0]         quo_t;
	typedef logic signed [COORD_BITS-1:0]  coord_t;
	typedef logic [CNT_BITS-1:0]           cnt_t;

	localparam face_t FACE_PX = 3'd0;
	localparam face_t FACE_PY = 3'd1;
	localparam face_t FACE_PZ = 3'd2;
	localparam face_t FACE_NX = 3'd3;
	localparam face_t FACE_NY = 3'd4;
	localparam face_t FACE_NZ = 3'd5;

	localparam status_t STAT_OK      = 2'd0;
	localparam status_t STAT_SAT     = 2'd1;
	localparam status_t STAT_ZERO    = 2'd2;
	localparam status_t STAT_INVALID = 2'd3;

	localparam logic FUNC_AUTO  = 1'b0;
	localparam logic FUNC_GIVEN = 1'b1;

	localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});
	localparam coord_t COORD_MAX = ~COORD_MIN;
	localparam cnt_t   CNT_DONE  = cnt_t'(COORD_BITS);

	typedef struct packed {
		face_t   face;
		status_t status;
		logic    neg_u;
		logic    neg_v;
		logic    ovf_u;
		logic    ovf_v;
		cnt_t    cnt;
	} side_t;

	typedef struct packed {
		mag_t rem;
		quo_t num;
		quo_t quo;
	} lane_t;

	typedef struct packed {
		side_t side;
		mag_t  den;
		lane_t u;
		lane_t v;
	} work_t;

endpackage

`default_nettype wire

// ===== rtl/cfs_ifs.sv =====
// ----------------------------------------------------------------------------
// cfs_ifs
// Valid/ready channels of the cube face select block: direction request and
// projected result.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfs_req_if;
	logic                  valid;
	logic                  ready;
	logic                  func;
	cfs_pkg::comp_t        vec_x;
	cfs_pkg::comp_t        vec_y;
	cfs_pkg::comp_t        vec_z;
	logic [2:0]            face_given;

	modport source (output valid, func, vec_x, vec_y, vec_z, face_given, input ready);
	modport sink   (input valid, func, vec_x, vec_y, vec_z, face_given, output ready);
endinterface

interface cfs_rsp_if;
	logic                  valid;
	logic                  ready;
	cfs_pkg::face_t        face;
	cfs_pkg::coord_t       coord_u;
	cfs_pkg::coord_t       coord_v;
	cfs_pkg::status_t      status;

	modport source (output valid, face, coord_u, coord_v, status, input ready);
	modport sink   (input valid, face, coord_u, coord_v, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfs_front.sv =====
// ----------------------------------------------------------------------------
// cfs_front
// First stage: face pick (major axis or given), canonical face coordinates,
// magnitudes and signs, and the quotient overflow check ahead of the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cfs_req_if.sink            req,
	output logic               out_valid,
	input  wire logic          out_ready,
	output cfs_pkg::work_t     out_data
);

	logic             valid_s1;
	cfs_pkg::work_t   data_s1;
	cfs_pkg::work_t   data_nx;

	cfs_pkg::mag_t    ax, ay, az;
	cfs_pkg::face_t   auto_face, sel_face;
	cfs_pkg::mag_t    m_u, m_v, m_d;
	logic             n_u, n_v, n_d;
	logic             invalid;
	cfs_pkg::num_t    num_u, num_v;
	cfs_pkg::mag_t    r0_u, r0_v;

	function automatic cfs_pkg::mag_t mag_of(input cfs_pkg::comp_t c);
		cfs_pkg::comp_t n;
		n = -c;
		return c[cfs_pkg::COMP_BITS-1] ? cfs_pkg::mag_t'(n) : cfs_pkg::mag_t'(c);
	endfunction

	function automatic logic is_pos(input cfs_pkg::comp_t c);
		return !c[cfs_pkg::COMP_BITS-1] && (|c);
	endfunction

	function automatic logic is_neg(input cfs_pkg::comp_t c);
		return c[cfs_pkg::COMP_BITS-1];
	endfunction

	always_comb begin
		ax = mag_of(req.vec_x);
		ay = mag_of(req.vec_y);
		az = mag_of(req.vec_z);

		if (ax >= ay && ax >= az) begin
			auto_face = is_pos(req.vec_x) ? cfs_pkg::FACE_PX : cfs_pkg::FACE_NX;
		end else if (ay >= az) begin
			auto_face = is_pos(req.vec_y) ? cfs_pkg::FACE_PY : cfs_pkg::FACE_NY;
		end else begin
			auto_face = is_pos(req.vec_z) ? cfs_pkg::FACE_PZ : cfs_pkg::FACE_NZ;
		end

		sel_face = (req.func == cfs_pkg::FUNC_GIVEN) ? req.face_given : auto_face;

		invalid = 1'b0;
		m_u = az;
		n_u = is_pos(req.vec_z);
		m_v = ay;
		n_v = is_neg(req.vec_y);
		m_d = ax;
		n_d = is_neg(req.vec_x);
		case (sel_face)
			cfs_pkg::FACE_PX: begin
				m_u = az; n_u = is_pos(req.vec_z);
				m_v = ay; n_v = is_neg(req.vec_y);
				m_d = ax; n_d = is_neg(req.vec_x);
			end
			cfs_pkg::FACE_NX: begin
				m_u = az; n_u = is_pos(req.vec_z);
				m_v = ay; n_v = is_pos(req.vec_y);
				m_d = ax; n_d = is_neg(req.vec_x);
			end
			cfs_pkg::FACE_PY: begin
				m_u = ax; n_u = is_neg(req.vec_x);
				m_v = az; n_v = is_pos(req.vec_z);
				m_d = ay; n_d = is_neg(req.vec_y);
			end
			cfs_pkg::FACE_NY: begin
				m_u = ax; n_u = is_pos(req.vec_x);
				m_v = az; n_v = is_pos(req.vec_z);
				m_d = ay; n_d = is_neg(req.vec_y);
			end
			cfs_pkg::FACE_PZ: begin
				m_u = ax; n_u = is_neg(req.vec_x);
				m_v = ay; n_v = is_neg(req.vec_y);
				m_d = az; n_d = is_neg(req.vec_z);
			end
			cfs_pkg::FACE_NZ: begin
				m_u = ax; n_u = is_neg(req.vec_x);
				m_v = ay; n_v = is_pos(req.vec_y);
				m_d = az; n_d = is_neg(req.vec_z);
			end
			default: begin
				invalid = 1'b1;
			end
		endcase

		num_u = {m_u, {cfs_pkg::FRAC_BITS{1'b0}}};
		num_v = {m_v, {cfs_pkg::FRAC_BITS{1'b0}}};
		r0_u  = cfs_pkg::mag_t'(num_u[cfs_pkg::NUM_BITS-1:cfs_pkg::COORD_BITS]);
		r0_v  = cfs_pkg::mag_t'(num_v[cfs_pkg::NUM_BITS-1:cfs_pkg::COORD_BITS]);

		data_nx.side.face   = invalid ? cfs_pkg::FACE_PX : sel_face;
		data_nx.side.status = invalid ? cfs_pkg::STAT_INVALID :
		                      (m_d == '0) ? cfs_pkg::STAT_ZERO : cfs_pkg::STAT_OK;
		data_nx.side.neg_u  = n_u ^ n_d;
		data_nx.side.neg_v  = n_v ^ n_d;
		data_nx.side.ovf_u  = (r0_u >= m_d);
		data_nx.side.ovf_v  = (r0_v >= m_d);
		data_nx.side.cnt    = '0;
		data_nx.den         = m_d;
		data_nx.u.rem       = r0_u;
		data_nx.u.num       = num_u[cfs_pkg::COORD_BITS-1:0];
		data_nx.u.quo       = '0;
		data_nx.v.rem       = r0_v;
		data_nx.v.num       = num_v[cfs_pkg::COORD_BITS-1:0];
		data_nx.v.quo       = '0;
	end

	assign req.ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			data_s1 <= data_nx;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

`default_nettype wire

// ===== rtl/cfs_divider.sv =====
// ----------------------------------------------------------------------------
// cfs_divider
// Pipelined restoring divider for both face coordinates: BITS_PER_STAGE quotient
// bits per stage, one step counter shared by the two lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_divider (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire cfs_pkg::work_t   in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output cfs_pkg::work_t        out_data
);

	logic             vld_s  [cfs_pkg::DIV_STAGES];
	cfs_pkg::work_t   data_s [cfs_pkg::DIV_STAGES];
	logic             src_v  [cfs_pkg::DIV_STAGES];
	cfs_pkg::work_t   src_d  [cfs_pkg::DIV_STAGES];
	logic             rdy    [cfs_pkg::DIV_STAGES+1];

	function automatic cfs_pkg::lane_t step_lane(input cfs_pkg::lane_t l,
	                                             input cfs_pkg::mag_t den);
		logic [cfs_pkg::COMP_BITS:0] t;
		logic [cfs_pkg::COMP_BITS:0] d;
		t = {l.rem, l.num[cfs_pkg::COORD_BITS-1]};
		d = {1'b0, den};
		l.num = l.num << 1;
		if (t >= d) begin
			t = t - d;
			l.quo = {l.quo[cfs_pkg::COORD_BITS-2:0], 1'b1};
		end else begin
			l.quo = {l.quo[cfs_pkg::COORD_BITS-2:0], 1'b0};
		end
		l.rem = t[cfs_pkg::COMP_BITS-1:0];
		return l;
	endfunction

	function automatic cfs_pkg::work_t step_stage(input cfs_pkg::work_t w);
		for (int k = 0; k < cfs_pkg::BITS_PER_STAGE; k++) begin
			if (w.side.cnt != cfs_pkg::CNT_DONE) begin
				w.u = step_lane(w.u, w.den);
				w.v = step_lane(w.v, w.den);
				w.side.cnt = w.side.cnt + 1'b1;
			end
		end
		return w;
	endfunction

	assign rdy[cfs_pkg::DIV_STAGES] = out_ready;
	assign in_ready                 = rdy[0];

	for (genvar i = 0; i < cfs_pkg::DIV_STAGES; i++) begin : g_stg
		if (i == 0) begin : g_first
			assign src_v[i] = in_valid;
			assign src_d[i] = in_data;
		end else begin : g_next
			assign src_v[i] = vld_s[i-1];
			assign src_d[i] = data_s[i-1];
		end

		assign rdy[i] = !vld_s[i] || rdy[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				vld_s[i] <= src_v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && src_v[i]) begin
				data_s[i] <= step_stage(src_d[i]);
			end
		end
	end

	assign out_valid = vld_s[cfs_pkg::DIV_STAGES-1];
	assign out_data  = data_s[cfs_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/cfs_back.sv =====
// ----------------------------------------------------------------------------
// cfs_back
// Last stage: sign, saturation and status, held in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire cfs_pkg::work_t   in_data,
	cfs_rsp_if.source             rsp
);

	logic                valid_q;
	cfs_pkg::face_t      face_q;
	cfs_pkg::coord_t     u_q, v_q;
	cfs_pkg::status_t    status_q;

	cfs_pkg::coord_t     u_nx, v_nx;
	logic                sat_u, sat_v;
	cfs_pkg::status_t    status_nx;

	function automatic cfs_pkg::coord_t fix_coord(input cfs_pkg::quo_t q, input logic neg,
	                                              input logic ovf, output logic sat);
		cfs_pkg::coord_t r;
		sat = 1'b0;
		if (neg && (ovf || q != '0)) begin
			if (ovf || q > cfs_pkg::quo_t'(cfs_pkg::COORD_MIN)) begin
				sat = 1'b1;
				r   = cfs_pkg::COORD_MIN;
			end else begin
				r = -cfs_pkg::coord_t'(q);
			end
		end else if (ovf || q[cfs_pkg::COORD_BITS-1]) begin
			sat = 1'b1;
			r   = cfs_pkg::COORD_MAX;
		end else begin
			r = cfs_pkg::coord_t'(q);
		end
		return r;
	endfunction

	always_comb begin
		u_nx = fix_coord(in_data.u.quo, in_data.side.neg_u, in_data.side.ovf_u, sat_u);
		v_nx = fix_coord(in_data.v.quo, in_data.side.neg_v, in_data.side.ovf_v, sat_v);
		if (in_data.side.status != cfs_pkg::STAT_OK) begin
			u_nx      = '0;
			v_nx      = '0;
			status_nx = in_data.side.status;
		end else begin
			status_nx = (sat_u || sat_v) ? cfs_pkg::STAT_SAT : cfs_pkg::STAT_OK;
		end
	end

	assign in_ready = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			face_q   <= in_data.side.face;
			u_q      <= u_nx;
			v_q      <= v_nx;
			status_q <= status_nx;
		end
	end

	assign rsp.valid   = valid_q;
	assign rsp.face    = face_q;
	assign rsp.coord_u = u_q;
	assign rsp.coord_v = v_q;
	assign rsp.status  = status_q;

endmodule

`default_nettype wire

// ===== rtl/cube_face_select_project.sv =====
// ----------------------------------------------------------------------------
// cube_face_select_project
// Cube map face selection and projection of a direction vector to Q3.14
// face coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one direction per transaction: func, vec_x/y/z and
//   face_given. func selects major axis face choice or projection onto
//   face_given. rsp returns face, coord_u, coord_v and status, one result
//   transaction per request transaction, in request order.
//   Throughput: one transaction per cycle, sustained while rsp is ready.
//   Stages: one stage for face choice and operand setup, DIV_STAGES
//   divider stages retiring BITS_PER_STAGE quotient bits each for both
//   coordinates, one result register.
//   The divider stage chain sets the latency.
//   Reset clears every stage valid bit; no result is pending afterwards.
//   When rsp stalls, the result register holds and stages fill up behind it;
//   req.ready drops only once every stage holds a transaction. Empty stages
//   close up, so a stall loses or repeats nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_face_select_project (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cfs_req_if.sink     req,
	cfs_rsp_if.source   rsp
);

	logic             f_valid, f_ready;
	cfs_pkg::work_t   f_data;
	logic             d_valid, d_ready;
	cfs_pkg::work_t   d_data;

	cfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	cfs_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_data  (d_data)
	);

	cfs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d_valid),
		.in_ready (d_ready),
		.in_data  (d_data),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// ===== rtl/cfs_checker.sv =====
// ----------------------------------------------------------------------------
// cfs_checker
// Port level checks of the cube face select block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire cfs_pkg::face_t     rsp_face,
	input wire cfs_pkg::coord_t    rsp_coord_u,
	input wire cfs_pkg::coord_t    rsp_coord_v,
	input wire cfs_pkg::status_t   rsp_status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_face) && $stable(rsp_coord_u)
		                            && $stable(rsp_coord_v) && $stable(rsp_status))
		else $error("result changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == cfs_pkg::STAT_INVALID |->
		rsp_face == cfs_pkg::FACE_PX && rsp_coord_u == '0 && rsp_coord_v == '0)
		else $error("invalid face result not cleared");

	a_zero_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == cfs_pkg::STAT_ZERO |->
		rsp_coord_u == '0 && rsp_coord_v == '0)
		else $error("zero depth result has nonzero coordinates");

endmodule

bind cube_face_select_project cfs_checker u_cfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_face    (rsp.face),
	.rsp_coord_u (rsp.coord_u),
	.rsp_coord_v (rsp.coord_v),
	.rsp_status  (rsp.status)
);

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cube_face_select_project. Directed directions cover
// component extremes, major axis ties, the all-zero vector, zero depth,
// exact and saturating quotients and every given face, valid or not; random
// directions follow. A behavioral projector computes the expected face,
// coordinates and status of each request transaction, and the monitor checks
// each result transaction against them in order, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;

	localparam int             CYCLE_LIMIT  = 200000;
	localparam int             RANDOM_ITEMS = 1230;
	localparam cfs_pkg::face_t FACE_BAD_LO  = 3'd6;
	localparam cfs_pkg::face_t FACE_BAD_HI  = 3'd7;

	typedef struct {
		logic           func;
		cfs_pkg::comp_t x;
		cfs_pkg::comp_t y;
		cfs_pkg::comp_t z;
		logic [2:0]     given;
		int             gap;
	} direction_t;

	typedef struct {
		cfs_pkg::face_t   face;
		cfs_pkg::coord_t  u;
		cfs_pkg::coord_t  v;
		cfs_pkg::status_t status;
	} proj_t;

	logic clk;
	logic arst_n;

	cfs_req_if req_ch ();
	cfs_rsp_if rsp_ch ();

	cube_face_select_project DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	direction_t dir_q[$];
	proj_t      proj_q[$];
	direction_t cur_dir;
	proj_t      want;
	int         gap_left;
	int         stall_left;
	int         stall_draw;
	int         fails;
	int         n_directed;
	int         n_sent;
	int         n_checked;
	int         n_sat;
	int         n_zero;
	int         n_invalid;
	int         cycles = 0;

	function automatic cfs_pkg::coord_t ratio_q(input longint num, input longint den,
			output bit clip);
		longint q;
		longint lim;
		lim  = longint'(1) << (cfs_pkg::COORD_BITS - 1);
		q    = ((num < 0 ? -num : num) << cfs_pkg::FRAC_BITS) / (den < 0 ? -den : den);
		clip = 1'b0;
		if (((num < 0) != (den < 0)) && q != 0) begin
			if (q > lim) begin
				clip = 1'b1;
				q    = lim;
			end
			return cfs_pkg::coord_t'(-q);
		end
		if (q > lim - 1) begin
			clip = 1'b1;
			q    = lim - 1;
		end
		return cfs_pkg::coord_t'(q);
	endfunction

	function automatic proj_t project_dir(input direction_t d);
		proj_t          r;
		cfs_pkg::face_t f;
		longint         sx, sy, sz, ax, ay, az, cu, cv, dep;
		bit             clip_u, clip_v;
		sx = longint'(d.x);
		sy = longint'(d.y);
		sz = longint'(d.z);
		ax = sx < 0 ? -sx : sx;
		ay = sy < 0 ? -sy : sy;
		az = sz < 0 ? -sz : sz;
		if (d.func == cfs_pkg::FUNC_AUTO) begin
			if (ax >= ay && ax >= az)
				f = sx > 0 ? cfs_pkg::FACE_PX : cfs_pkg::FACE_NX;
			else if (ay >= az)
				f = sy > 0 ? cfs_pkg::FACE_PY : cfs_pkg::FACE_NY;
			else
				f = sz > 0 ? cfs_pkg::FACE_PZ : cfs_pkg::FACE_NZ;
		end else begin
			f = d.given;
		end
		r.face   = f;
		r.u      = '0;
		r.v      = '0;
		r.status = cfs_pkg::STAT_OK;
		case (f)
			cfs_pkg::FACE_PX: begin cu = -sz; cv = sy;  dep = sx; end
			cfs_pkg::FACE_NX: begin cu = -sz; cv = -sy; dep = sx; end
			cfs_pkg::FACE_PY: begin cu = sx;  cv = -sz; dep = sy; end
			cfs_pkg::FACE_NY: begin cu = -sx; cv = -sz; dep = sy; end
			cfs_pkg::FACE_PZ: begin cu = sx;  cv = sy;  dep = sz; end
			cfs_pkg::FACE_NZ: begin cu = sx;  cv = -sy; dep = sz; end
			default: begin
				r.face   = cfs_pkg::FACE_PX;
				r.status = cfs_pkg::STAT_INVALID;
				return r;
			end
		endcase
		if (dep == 0) begin
			r.status = cfs_pkg::STAT_ZERO;
			return r;
		end
		r.u      = ratio_q(cu, dep, clip_u);
		r.v      = ratio_q(cv, dep, clip_v);
		r.status = (clip_u || clip_v) ? cfs_pkg::STAT_SAT : cfs_pkg::STAT_OK;
		return r;
	endfunction

	function automatic direction_t direction(input logic func, input int x, input int y,
			input int z, input cfs_pkg::face_t given);
		direction_t d;
		d.func  = func;
		d.x     = cfs_pkg::comp_t'(x);
		d.y     = cfs_pkg::comp_t'(y);
		d.z     = cfs_pkg::comp_t'(z);
		d.given = given;
		d.gap   = $urandom_range(0, 3);
		return d;
	endfunction

	function automatic cfs_pkg::comp_t extreme_comp();
		case ($urandom_range(0, 4))
			0: return cfs_pkg::comp_t'(-32768);
			1: return cfs_pkg::comp_t'(-1);
			2: return cfs_pkg::comp_t'(0);
			3: return cfs_pkg::comp_t'(1);
			default: return cfs_pkg::comp_t'(32767);
		endcase
	endfunction

	function automatic direction_t random_direction(input int idx);
		direction_t d;
		int         m;
		logic [4:0] sel;
		d.func  = cfs_pkg::FUNC_AUTO;
		d.x     = cfs_pkg::comp_t'($urandom);
		d.y     = cfs_pkg::comp_t'($urandom);
		d.z     = cfs_pkg::comp_t'($urandom);
		d.given = 3'($urandom_range(0, 7));
		d.gap   = ((idx / 100) % 4 == 3) ? 0 : $urandom_range(0, 3);
		sel     = 5'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;
			4: begin
				m   = $urandom_range(0, 32767);
				d.x = cfs_pkg::comp_t'(sel[0] ? -m : m);
				d.y = cfs_pkg::comp_t'(sel[1] ? -m : m);
				d.z = cfs_pkg::comp_t'(sel[2] ? -m : m);
				case (sel[4:3])
					2'd0: d.x = '0;
					2'd1: d.z = cfs_pkg::comp_t'(m / 2);
					2'd2: d.y = '0;
					default: ;
				endcase
			end
			5, 6: begin
				d.func  = cfs_pkg::FUNC_GIVEN;
				d.given = 3'($urandom_range(0, 5));
			end
			7: begin
				d.func = cfs_pkg::FUNC_GIVEN;
				m      = $urandom_range(0, 8) - 4;
				case (d.given % 3)
					0: d.x = cfs_pkg::comp_t'(m);
					1: d.y = cfs_pkg::comp_t'(m);
					default: d.z = cfs_pkg::comp_t'(m);
				endcase
			end
			8: d.func = cfs_pkg::FUNC_GIVEN;
			default: begin
				d.func = sel[0];
				d.x    = extreme_comp();
				d.y    = extreme_comp();
				d.z    = extreme_comp();
			end
		endcase
		return d;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.func       <= cfs_pkg::FUNC_AUTO;
			req_ch.vec_x      <= '0;
			req_ch.vec_y      <= '0;
			req_ch.vec_z      <= '0;
			req_ch.face_given <= '0;
			gap_left          <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				proj_q.push_back(project_dir(cur_dir));
				n_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left != 0) begin
					req_ch.valid <= 1'b0;
					gap_left     <= gap_left - 1;
				end else if (dir_q.size() != 0) begin
					cur_dir            = dir_q.pop_front();
					req_ch.valid      <= 1'b1;
					req_ch.func       <= cur_dir.func;
					req_ch.vec_x      <= cur_dir.x;
					req_ch.vec_y      <= cur_dir.y;
					req_ch.vec_z      <= cur_dir.z;
					req_ch.face_given <= cur_dir.given;
					gap_left          <= cur_dir.gap;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= 2;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			if (proj_q.size() == 0) begin
				$error("result with no pending transaction: face %0d u %0d v %0d status %0d",
					rsp_ch.face, rsp_ch.coord_u, rsp_ch.coord_v, rsp_ch.status);
				fails++;
			end else begin
				want = proj_q.pop_front();
				n_checked++;
				case (want.status)
					cfs_pkg::STAT_SAT:     n_sat++;
					cfs_pkg::STAT_ZERO:    n_zero++;
					cfs_pkg::STAT_INVALID: n_invalid++;
					default: ;
				endcase
				if (rsp_ch.face !== want.face) begin
					$error("face: expected %0d, got %0d", want.face, rsp_ch.face);
					fails++;
				end
				if (rsp_ch.coord_u !== want.u) begin
					$error("coord_u: expected %0d, got %0d", want.u, rsp_ch.coord_u);
					fails++;
				end
				if (rsp_ch.coord_v !== want.v) begin
					$error("coord_v: expected %0d, got %0d", want.v, rsp_ch.coord_v);
					fails++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					fails++;
				end
			end
			if ((n_checked / 150) % 3 == 2) begin
				rsp_ch.ready <= 1'b1;
				stall_left   <= 0;
			end else begin
				stall_draw    = $urandom_range(0, 3);
				stall_left   <= stall_draw;
				rsp_ch.ready <= (stall_draw == 0);
			end
		end else if (stall_left != 0) begin
			rsp_ch.ready <= (stall_left == 1);
			stall_left   <= stall_left - 1;
		end
	end

	initial begin
		arst_n    = 1'b0;
		fails     = 0;
		n_sent    = 0;
		n_checked = 0;
		n_sat     = 0;
		n_zero    = 0;
		n_invalid = 0;

		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, 0, 0, 0, cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, 32767, 0, 0, FACE_BAD_HI));
		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, -32768, 0, 0, cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, 0, 32767, -5, cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, 0, -32768, 100, cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, 3, -4, 32767, cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, 1, 2, -32768, cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, 100, 100, 100, cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, -100, 100, -100, cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, 0, 50, -50, cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, 0, -50, 50, cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_AUTO, -32768, 32767, -32768,
			cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_GIVEN, 32767, -32768, 1, cfs_pkg::FACE_PX));
		dir_q.push_back(direction(cfs_pkg::FUNC_GIVEN, -32768, 1, 32767, cfs_pkg::FACE_PY));
		dir_q.push_back(direction(cfs_pkg::FUNC_GIVEN, -8, 7, 1, cfs_pkg::FACE_PZ));
		dir_q.push_back(direction(cfs_pkg::FUNC_GIVEN, 8, -8, 1, cfs_pkg::FACE_PZ));
		dir_q.push_back(direction(cfs_pkg::FUNC_GIVEN, -1, 32767, -32768, cfs_pkg::FACE_NX));
		dir_q.push_back(direction(cfs_pkg::FUNC_GIVEN, 1234, -2, -4321, cfs_pkg::FACE_NY));
		dir_q.push_back(direction(cfs_pkg::FUNC_GIVEN, -32768, -32768, -32768,
			cfs_pkg::FACE_NZ));
		dir_q.push_back(direction(cfs_pkg::FUNC_GIVEN, 5, -7, 0, cfs_pkg::FACE_PZ));
		dir_q.push_back(direction(cfs_pkg::FUNC_GIVEN, 0, 9, 9, cfs_pkg::FACE_NX));
		dir_q.push_back(direction(cfs_pkg::FUNC_GIVEN, 100, 200, 300, FACE_BAD_LO));
		dir_q.push_back(direction(cfs_pkg::FUNC_GIVEN, -1, -1, -1, FACE_BAD_HI));
		n_directed = dir_q.size();
		for (int i = 0; i < RANDOM_ITEMS; i++)
			dir_q.push_back(random_direction(i));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (dir_q.size() != 0 || req_ch.valid) @(posedge clk);
		while (proj_q.size() != 0) @(posedge clk);
		repeat (4 * (cfs_pkg::DIV_STAGES + 2)) @(posedge clk);

		$display("%0d directions driven (%0d directed), %0d results checked",
			n_sent, n_directed, n_checked);
		$display("%0d saturated, %0d zero depth, %0d invalid face", n_sat, n_zero, n_invalid);
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
